/* sv/prime_test_trial_division_defines.svh */
// Assertion macros shared by the trial division primality tester.
// Depends on the module that uses them having i_clk and i_rst_n.
`ifndef PRIME_TEST_TRIAL_DIVISION_DEFINES_SVH
`define PRIME_TEST_TRIAL_DIVISION_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ptd_pkg.sv */
// Package for the trial division primality tester: word types, codes, states.
// Used by ptd_mod and prime_test_trial_division; depends on nothing.
`timescale 1ns / 1ps

package ptd_pkg;

    // Widths of the shared remainder unit, of one table entry and of the output prime count.
    localparam int DIV_WIDTH   = 32;
    localparam int PRIME_WIDTH = 16;
    localparam int COUNT_OUT_WIDTH = 14;

    // Action codes of an input word.
    localparam logic ACT_BUILD = 1'b0;
    localparam logic ACT_TEST  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic                       is_prime;
        logic                       beyond_limit;
        logic [COUNT_OUT_WIDTH-1:0] prime_count;
    } t_out_word;

    // Status of the remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } t_mod_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BCAND,
        S_RD,
        S_CHK,
        S_MOD,
        S_OUT
    } t_state;

endpackage

/* sv/ptd_mod.sv */
// Bit-serial restoring remainder unit: dividend mod divisor, one bit a cycle.
// Depends on ptd_pkg for widths and the status struct.
`timescale 1ns / 1ps

module ptd_mod (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ptd_pkg::DIV_WIDTH-1:0]     i_dividend,
    input  logic [ptd_pkg::PRIME_WIDTH-1:0]   i_divisor,
    output ptd_pkg::t_mod_status              o_status
);

    localparam int CW = $clog2(ptd_pkg::DIV_WIDTH);

    logic                            r_busy;
    logic                            r_done;
    logic [CW-1:0]                   r_cnt;
    logic [ptd_pkg::PRIME_WIDTH-1:0] r_rem;
    logic [ptd_pkg::DIV_WIDTH-1:0]   r_dvd;
    logic [ptd_pkg::PRIME_WIDTH-1:0] r_div;
    logic [ptd_pkg::PRIME_WIDTH:0]   w_trial;

    // Shift in the next dividend bit and subtract when it fits.
    assign w_trial = {r_rem, r_dvd[ptd_pkg::DIV_WIDTH-1]};

    // Control: busy for one cycle per dividend bit, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ptd_pkg::DIV_WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and dividend shifter.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            if (w_trial >= {1'b0, r_div}) begin
                r_rem <= ptd_pkg::PRIME_WIDTH'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= w_trial[ptd_pkg::PRIME_WIDTH-1:0];
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.zero = (r_rem == '0);

endmodule

/* sv/prime_test_trial_division.sv */
// Trial division primality tester. A test walks the table primes until a match, a
// divisor or the end of the table; a build walks them for every candidate until a divisor,
// a prime whose square exceeds it or the end of the table. Each remainder step of the walk
// is one table read, one check, one bit step of the shared remainder unit per dividend bit
// and its done pulse. One word at a time; the result holds until taken. Reset
// (synchronous, low) empties the table and clears the limit at once; the table needs no clearing.
`timescale 1ns / 1ps
`include "prime_test_trial_division_defines.svh"

module prime_test_trial_division #(
    parameter int TABLE_DEPTH  = 8192,
    parameter int NUMBER_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ptd_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ptd_pkg::t_out_word o_out_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = ptd_pkg::PRIME_WIDTH;
    localparam int XW = PW + 1;

    ptd_pkg::t_state      r_state;
    ptd_pkg::t_state      n_state;
    logic                 r_act;
    logic                 r_isp;
    logic                 r_bey;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_idx;
    logic [XW-1:0]        r_cand;
    logic [NUMBER_WIDTH-1:0] r_num;
    logic [NUMBER_WIDTH-1:0] r_limit;
    logic [PW-1:0]        r_mem [TABLE_DEPTH];
    logic [PW-1:0]        r_rdata;

    logic                 w_we;
    logic                 w_rd;
    logic                 w_mod_start;
    logic                 w_in_acc;
    logic                 w_out_acc;
    logic                 w_cand_done;
    logic                 w_walk_end;
    logic                 w_p_big;
    logic                 w_n_eq;
    logic [NUMBER_WIDTH-1:0] w_value;
    logic [ptd_pkg::DIV_WIDTH-1:0] w_dividend;
    ptd_pkg::t_mod_status w_mod;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;
    assign w_value   = i_in_data.value[NUMBER_WIDTH-1:0];

    // Loop conditions of the sequencer.
    assign w_cand_done = ((r_cand * r_cand) >= (2*XW)'(r_limit))
                         || (r_count == CW'(TABLE_DEPTH));
    assign w_walk_end  = (r_idx == r_count);
    assign w_p_big     = (r_rdata * r_rdata) > (2*PW)'(r_cand);
    assign w_n_eq      = (32'(r_num) == 32'(r_rdata));
    assign w_dividend  = (r_act == ptd_pkg::ACT_BUILD) ? ptd_pkg::DIV_WIDTH'(r_cand)
                                                       : ptd_pkg::DIV_WIDTH'(r_num);

    // Shared remainder unit.
    ptd_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_rdata),
        .o_status   (w_mod)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptd_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.action == ptd_pkg::ACT_BUILD) begin
                        n_state = ptd_pkg::S_BCAND;
                    end else if (w_value < NUMBER_WIDTH'(2)) begin
                        n_state = ptd_pkg::S_OUT;
                    end else begin
                        n_state = ptd_pkg::S_RD;
                    end
                end
            end
            ptd_pkg::S_BCAND: begin
                n_state = w_cand_done ? ptd_pkg::S_OUT : ptd_pkg::S_RD;
            end
            ptd_pkg::S_RD: begin
                if (!w_walk_end) begin
                    n_state = ptd_pkg::S_CHK;
                end else if (r_act == ptd_pkg::ACT_BUILD) begin
                    n_state = ptd_pkg::S_BCAND;
                end else begin
                    n_state = ptd_pkg::S_OUT;
                end
            end
            ptd_pkg::S_CHK: begin
                if (r_act == ptd_pkg::ACT_BUILD) begin
                    n_state = w_p_big ? ptd_pkg::S_BCAND : ptd_pkg::S_MOD;
                end else begin
                    n_state = w_n_eq ? ptd_pkg::S_OUT : ptd_pkg::S_MOD;
                end
            end
            ptd_pkg::S_MOD: begin
                if (w_mod.done) begin
                    if (!w_mod.zero) begin
                        n_state = ptd_pkg::S_RD;
                    end else if (r_act == ptd_pkg::ACT_BUILD) begin
                        n_state = ptd_pkg::S_BCAND;
                    end else begin
                        n_state = ptd_pkg::S_OUT;
                    end
                end
            end
            ptd_pkg::S_OUT: begin
                if (w_out_acc) begin
                    n_state = ptd_pkg::S_IDLE;
                end
            end
            default: n_state = ptd_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_ready  = (r_state == ptd_pkg::S_IDLE);
        o_out_valid = (r_state == ptd_pkg::S_OUT);
        w_rd        = (r_state == ptd_pkg::S_RD) && !w_walk_end;
        w_we        = (r_act == ptd_pkg::ACT_BUILD)
                      && (((r_state == ptd_pkg::S_RD) && w_walk_end)
                          || ((r_state == ptd_pkg::S_CHK) && w_p_big));
        w_mod_start = (r_state == ptd_pkg::S_CHK)
                      && ((r_act == ptd_pkg::ACT_BUILD) ? !w_p_big : !w_n_eq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Count, limit, action and result flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_limit <= '0;
            r_act   <= ptd_pkg::ACT_BUILD;
            r_isp   <= 1'b0;
            r_bey   <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_act <= i_in_data.action;
                r_isp <= 1'b0;
                r_bey <= 1'b0;
                if (i_in_data.action == ptd_pkg::ACT_BUILD) begin
                    r_count <= '0;
                    r_limit <= w_value;
                end else begin
                    r_bey <= (w_value >= r_limit);
                end
            end
            if (w_we) begin
                r_count <= r_count + 1'b1;
            end
            // A test ends prime on a walk past the table or a table match.
            if (r_act == ptd_pkg::ACT_TEST) begin
                if ((r_state == ptd_pkg::S_RD) && w_walk_end) begin
                    r_isp <= 1'b1;
                end else if ((r_state == ptd_pkg::S_CHK) && w_n_eq) begin
                    r_isp <= 1'b1;
                end
            end
        end
    end

    // Candidate, test number and walk index.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cand <= XW'(2);
            r_num  <= w_value;
            r_idx  <= '0;
        end else begin
            if (r_state == ptd_pkg::S_BCAND) begin
                r_idx <= '0;
            end
            if (w_rd) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_we || ((r_state == ptd_pkg::S_MOD) && w_mod.done && w_mod.zero)) begin
                r_cand <= r_cand + 1'b1;
            end
        end
    end

    // Prime table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[AW-1:0]] <= r_cand[PW-1:0];
        end
        if (w_rd) begin
            r_rdata <= r_mem[r_idx[AW-1:0]];
        end
    end

    assign o_out_data.is_prime     = r_isp;
    assign o_out_data.beyond_limit = r_bey;
    assign o_out_data.prime_count  = ptd_pkg::COUNT_OUT_WIDTH'(r_count);

    `PTD_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(TABLE_DEPTH), "table count overflow")
    `PTD_ASSERT_NOW(a_one_side, o_out_valid, !o_in_ready, "input taken while result pending")
    `PTD_ASSERT_NOW(a_mod_state, w_mod.done, r_state == ptd_pkg::S_MOD, "stray remainder done")
    `PTD_ASSERT_NEXT(a_out_drop, w_out_acc, !o_out_valid, "result repeated")
    `PTD_ASSERT_NOW(a_build_flags, o_out_valid && (r_act == ptd_pkg::ACT_BUILD),
                    !r_isp && !r_bey, "build result flags set")

endmodule
